// ===== design/ipe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipe_pkg - image patch extractor shared definitions
// Field widths, command and status codes, register indexes and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ipe_pkg;

  localparam int PIX_W       = 32;
  localparam int IDX_W       = 23;
  localparam int CMD_W       = 2;
  localparam int CHC_W       = 3;
  localparam int DIM_W       = 7;
  localparam int OFS_W       = 6;
  localparam int PATCH_MAX   = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;
  // origin plus stride plus side
  localparam int GEO_W       = 9;
  // product of two dimensions
  localparam int DIMP_W      = 14;
  localparam int TOT_W       = 17;
  localparam int PLEN_W      = 15;
  localparam int PREP_CYCLES = 2;
  localparam int PREP_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_EMIT   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_LOADED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATCH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_SLOT = 3'd5;

  typedef struct packed {
    logic accept;
    logic deliver;
  } dp_cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== design/ipe_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipe_in_if - request channel into the patch extractor
// Valid/ready channel carrying a command and a pixel word.
// ----------------------------------------------------------------------------
interface ipe_in_if import ipe_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [PIX_W-1:0] pixel_word;

  modport source (output valid, output command, output pixel_word, input ready);
  modport sink   (input valid, input command, input pixel_word, output ready);

endinterface

// ===== design/ipe_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipe_out_if - result channel out of the patch extractor
// Valid/ready channel carrying one patch element or a status.
// ----------------------------------------------------------------------------
interface ipe_out_if import ipe_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] element_word;
  logic [IDX_W-1:0] element_index;
  logic             patch_end;
  logic             image_end;
  logic [1:0]       status;

  modport source (output valid, output element_word, output element_index,
                  output patch_end, output image_end, output status, input ready);
  modport sink   (input valid, input element_word, input element_index,
                  input patch_end, input image_end, input status, output ready);

endinterface

// ===== design/ipe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipe_ram - generic single-port-write RAM with registered read
// One write and one read address per cycle; read data held until next read.
// ----------------------------------------------------------------------------
module ipe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ipe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipe_ctrl - patch extractor controller
// Takes requests, waits for derived sizes to settle after configuration and
// hands each result from the read stage to the output register.
// ----------------------------------------------------------------------------
module ipe_ctrl import ipe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_we,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_t;

  state_t            state_r, state_nxt;
  logic [PREP_W-1:0] prep_r, prep_nxt;

  always_comb begin
    in_ready    = (state_r == S_IDLE) && (prep_r == '0) && !cfg_we;
    cmd.accept  = in_ready && in_valid;
    cmd.deliver = (state_r == S_HOLD) && sts.out_free;
    state_nxt   = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && sts.has_result) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (cmd.deliver) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    prep_nxt = prep_r;
    if (cfg_we) begin
      prep_nxt = PREP_W'(PREP_CYCLES);
    end else if (prep_r != '0) begin
      prep_nxt = prep_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      prep_r  <= PREP_W'(PREP_CYCLES);
    end else begin
      state_r <= state_nxt;
      prep_r  <= prep_nxt;
    end
  end

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && !sts.out_free) |=> (state_r == S_HOLD))
    else $error("held result left the read stage while output was full");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("request taken before derived sizes settled");

endmodule

// ===== design/ipe_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipe_datapath - patch extractor datapath
// Configuration registers, derived sizes, load and patch counters, pixel
// store, read stage and output register.
// ----------------------------------------------------------------------------
module ipe_datapath import ipe_pkg::*; #(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_WIDTH    = 64,
  parameter int WORD_BITS    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [PIX_W-1:0]      in_pixel_word,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_element_word,
  output logic [IDX_W-1:0]      out_element_index,
  output logic                  out_patch_end,
  output logic                  out_image_end,
  output logic [1:0]            out_status
);

  localparam int DEPTH      = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CHP_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int STORE_BITS = (WORD_BITS < PIX_W) ? WORD_BITS : PIX_W;

  // configuration
  logic [CHC_W-1:0] cfg_ch_r;
  logic [DIM_W-1:0] cfg_h_r, cfg_w_r, cfg_p_r, cfg_s_r;
  logic             cfg_cls_r;
  logic             cfg_hit;

  logic [CHC_W-1:0]  ch_c;
  logic [DIM_W-1:0]  h_c, w_c, p_c, s_c;
  logic [DIMP_W-1:0] h_x, w_x, p_x, s_x;

  // derived sizes
  logic [DIMP_W-1:0] hw_r, sw_r, pp_r;
  logic              fits_r;
  logic [TOT_W-1:0]  total_r;
  logic [PLEN_W-1:0] plen_r;

  // progress
  logic [CNT_W-1:0] load_cnt_r;
  logic [OFS_W-1:0] cip_r, rip_r;
  logic [CHP_W-1:0] chan_r;
  logic [DIM_W-1:0] co_r, ro_r;
  logic [AW-1:0]    prow_r, porg_r, cbase_r, rbase_r;
  logic [IDX_W-1:0] idx_r;
  logic             emit_done_r;

  // read stage and output
  logic             res_rd_r, res_pend_r, res_iend_r;
  logic [IDX_W-1:0] res_idx_r;
  status_t          res_status_r;
  logic             out_valid_r, out_pend_r, out_iend_r;
  logic [PIX_W-1:0] out_word_r;
  logic [IDX_W-1:0] out_idx_r;
  status_t          out_status_r;

  cmd_code_t cmd_code;
  logic      load_full, emit_ok, is_load, is_emit, step, clear_emit;
  logic      col_last, row_last, chan_last, co_fit, ro_fit, pend, iend;
  logic [AW-1:0]    addr, porg_col_nxt, prow_row_nxt, cbase_ch_nxt;
  logic [IDX_W-1:0] elem_idx;
  status_t          emit_status;

  logic                  ram_we, ram_re;
  logic [STORE_BITS-1:0] ram_rdata;

  always_comb begin
    case (cfg_index)
      REG_CHANNELS, REG_HEIGHT, REG_WIDTH,
      REG_PATCH, REG_STRIDE, REG_CLASS_SLOT: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch_r  <= 3'd3;
      cfg_h_r   <= 7'd64;
      cfg_w_r   <= 7'd64;
      cfg_p_r   <= 7'd16;
      cfg_s_r   <= 7'd0;
      cfg_cls_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNELS:   cfg_ch_r  <= cfg_data[CHC_W-1:0];
        REG_HEIGHT:     cfg_h_r   <= cfg_data[DIM_W-1:0];
        REG_WIDTH:      cfg_w_r   <= cfg_data[DIM_W-1:0];
        REG_PATCH:      cfg_p_r   <= cfg_data[DIM_W-1:0];
        REG_STRIDE:     cfg_s_r   <= cfg_data[DIM_W-1:0];
        REG_CLASS_SLOT: cfg_cls_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturate sizes into range
  always_comb begin
    if (cfg_ch_r == '0) ch_c = CHC_W'(1);
    else if (int'(cfg_ch_r) > MAX_CHANNELS) ch_c = CHC_W'(MAX_CHANNELS);
    else ch_c = cfg_ch_r;
    if (cfg_h_r == '0) h_c = DIM_W'(1);
    else if (int'(cfg_h_r) > MAX_HEIGHT) h_c = DIM_W'(MAX_HEIGHT);
    else h_c = cfg_h_r;
    if (cfg_w_r == '0) w_c = DIM_W'(1);
    else if (int'(cfg_w_r) > MAX_WIDTH) w_c = DIM_W'(MAX_WIDTH);
    else w_c = cfg_w_r;
    if (cfg_p_r == '0) p_c = DIM_W'(1);
    else if (int'(cfg_p_r) > PATCH_MAX) p_c = DIM_W'(PATCH_MAX);
    else p_c = cfg_p_r;
    s_c = (cfg_s_r == '0) ? p_c : cfg_s_r;
    h_x = DIMP_W'(h_c);
    w_x = DIMP_W'(w_c);
    p_x = DIMP_W'(p_c);
    s_x = DIMP_W'(s_c);
  end

  // two settling stages of derived sizes
  always_ff @(posedge clk) begin
    hw_r    <= h_x * w_x;
    sw_r    <= s_x * w_x;
    pp_r    <= p_x * p_x;
    fits_r  <= (h_c >= p_c) && (w_c >= p_c);
    total_r <= TOT_W'(ch_c) * TOT_W'(hw_r);
    plen_r  <= PLEN_W'(ch_c) * PLEN_W'(pp_r);
  end

  always_comb begin
    cmd_code = cmd_code_t'(in_command);
    is_load  = (cmd_code == CMD_LOAD);
    is_emit  = (cmd_code == CMD_EMIT);
    sts.has_result = is_load || is_emit;
    sts.out_free   = !out_valid_r || out_ready;

    load_full = 32'(load_cnt_r) >= 32'(total_r);
    emit_ok   = load_full && fits_r && !emit_done_r;
    if (!load_full) emit_status = ST_NOT_LOADED;
    else if (!emit_ok) emit_status = ST_EMPTY;
    else emit_status = ST_OK;
    step       = cmd.accept && is_emit && emit_ok;
    clear_emit = cfg_hit || (cmd.accept && cmd_code == CMD_START);

    col_last  = (int'(cip_r) + 1) >= int'(p_c);
    row_last  = (int'(rip_r) + 1) >= int'(p_c);
    chan_last = (int'(chan_r) + 1) >= int'(ch_c);
    co_fit    = (GEO_W'(co_r) + GEO_W'(s_c) + GEO_W'(p_c)) <= GEO_W'(w_c);
    ro_fit    = (GEO_W'(ro_r) + GEO_W'(s_c) + GEO_W'(p_c)) <= GEO_W'(h_c);
    pend      = col_last && row_last && chan_last;
    iend      = pend && !co_fit && !ro_fit;

    addr         = rbase_r + AW'(cip_r);
    cbase_ch_nxt = cbase_r + AW'(hw_r);
    porg_col_nxt = porg_r + AW'(s_c);
    prow_row_nxt = prow_r + AW'(sw_r);
    elem_idx     = idx_r + (cfg_cls_r ? IDX_W'(plen_r) : IDX_W'(0));

    ram_we = cmd.accept && is_load && !load_full;
    ram_re = step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else if (cmd.accept && cmd_code == CMD_START) begin
      load_cnt_r <= '0;
    end else if (ram_we) begin
      load_cnt_r <= load_cnt_r + 1'b1;
    end
  end

  // patch walk: column, row, channel, patch column, patch row
  always_ff @(posedge clk) begin
    if (!rst_n || clear_emit) begin
      cip_r       <= '0;
      rip_r       <= '0;
      chan_r      <= '0;
      co_r        <= '0;
      ro_r        <= '0;
      prow_r      <= '0;
      porg_r      <= '0;
      cbase_r     <= '0;
      rbase_r     <= '0;
      idx_r       <= '0;
      emit_done_r <= 1'b0;
    end else if (step) begin
      idx_r <= idx_r + 1'b1;
      if (!col_last) begin
        cip_r <= cip_r + 1'b1;
      end else begin
        cip_r <= '0;
        if (!row_last) begin
          rip_r   <= rip_r + 1'b1;
          rbase_r <= rbase_r + AW'(w_c);
        end else begin
          rip_r <= '0;
          if (!chan_last) begin
            chan_r  <= chan_r + 1'b1;
            cbase_r <= cbase_ch_nxt;
            rbase_r <= cbase_ch_nxt;
          end else begin
            chan_r <= '0;
            if (co_fit) begin
              co_r    <= co_r + s_c;
              porg_r  <= porg_col_nxt;
              cbase_r <= porg_col_nxt;
              rbase_r <= porg_col_nxt;
            end else begin
              co_r <= '0;
              if (ro_fit) begin
                ro_r    <= ro_r + s_c;
                prow_r  <= prow_row_nxt;
                porg_r  <= prow_row_nxt;
                cbase_r <= prow_row_nxt;
                rbase_r <= prow_row_nxt;
              end else begin
                ro_r        <= '0;
                prow_r      <= '0;
                porg_r      <= '0;
                cbase_r     <= '0;
                rbase_r     <= '0;
                emit_done_r <= 1'b1;
              end
            end
          end
        end
      end
    end
  end

  ipe_ram #(
    .WIDTH (STORE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_cnt_r[AW-1:0]),
    .wdata (in_pixel_word[STORE_BITS-1:0]),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_rd_r   <= step;
      res_idx_r  <= step ? elem_idx : '0;
      res_pend_r <= step && pend;
      res_iend_r <= step && iend;
      if (is_load) res_status_r <= load_full ? ST_OVERFLOW : ST_OK;
      else res_status_r <= emit_status;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_word_r   <= res_rd_r ? PIX_W'(ram_rdata) : '0;
      out_idx_r    <= res_idx_r;
      out_pend_r   <= res_pend_r;
      out_iend_r   <= res_iend_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_element_word  = out_word_r;
  assign out_element_index = out_idx_r;
  assign out_patch_end     = out_pend_r;
  assign out_image_end     = out_iend_r;
  assign out_status        = out_status_r;

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store written and read in the same cycle");

  a_done_set: assert property (@(posedge clk) disable iff (!rst_n)
    (step && iend) |=> emit_done_r)
    else $error("last element of image did not close emission");

  a_end_nest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_iend_r) |-> out_pend_r)
    else $error("image end without patch end");

endmodule

// ===== design/image_patch_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_patch_extractor - patch cut of one channel-major image
// Loads an image into a pixel store and emits it as square patches, one
// element per emit request, with its output index and end flags.
// ----------------------------------------------------------------------------
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    command, pixel_word
//   out_ch   out  valid/ready    element_word, element_index, patch_end,
//                                image_end, status
//   cfg_*    in   cfg_we only    cfg_index, cfg_data
//
// start gives no result; load and emit pass the accept, the registered store
// read in the read stage and then the output register; a result waits in the
// read stage while the output register is full. after reset and after any
// register write the block takes no request while the derived sizes (products
// of height, width, stride, patch side and channels) settle; the store needs no clearing pass.
// a result waiting in the output register does not block the next request;
// a second result waits in the read stage until the output register frees.
// ----------------------------------------------------------------------------
module image_patch_extractor import ipe_pkg::*; #(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_WIDTH    = 64,
  parameter int WORD_BITS    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ipe_in_if.sink                in_ch,
  ipe_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;
  logic    out_valid;

  ipe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipe_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_WIDTH    (MAX_WIDTH),
    .WORD_BITS    (WORD_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_command        (in_ch.command),
    .in_pixel_word     (in_ch.pixel_word),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ch.ready),
    .out_element_word  (out_ch.element_word),
    .out_element_index (out_ch.element_index),
    .out_patch_end     (out_ch.patch_end),
    .out_image_end     (out_ch.image_end),
    .out_status        (out_ch.status)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

// ===== bench/image_patch_extractor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_patch_extractor_tb - self-checking bench for the patch extractor
// Drives start, load and emit requests over the valid/ready input channel and
// writes the geometry registers between images. A behavioural predictor keeps
// its own copy of the pixel store and sweep counters and queues the expected
// element or status for every request; each result taken from the output
// channel is compared field by field with the oldest entry. Both channels
// stall at random, with occasional stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module image_patch_extractor_tb;
  import ipe_pkg::*;

  localparam int STORE_WORDS = 16384;
  localparam int STORE_AW    = $clog2(STORE_WORDS);
  localparam int MAX_IDLE    = 13;

  typedef struct packed {
    logic [PIX_W-1:0] word;
    logic [IDX_W-1:0] index;
    logic             patch_end;
    logic             image_end;
    status_t          status;
  } element_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ipe_in_if  in_ch ();
  ipe_out_if out_ch ();

  image_patch_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers, store and sweep position
  logic [CHC_W-1:0] r_channels;
  logic [DIM_W-1:0] r_height, r_width, r_patch, r_stride;
  logic             r_class_slot;
  logic [PIX_W-1:0] pix_mem [STORE_WORDS];
  int unsigned      pix_loaded;
  int unsigned      prow, pcol, pchan, prip, pcip;
  bit               sweep_done;
  int unsigned      g_ch, g_h, g_w, g_p, g_s, g_total, g_rows, g_cols, g_plen;

  element_t    expected_q[$];
  int unsigned mismatch_count;
  int unsigned requests_sent;
  bit          no_stall;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void refresh_geometry();
    g_ch    = clamp_dim(32'(r_channels), 4);
    g_h     = clamp_dim(32'(r_height), 64);
    g_w     = clamp_dim(32'(r_width), 64);
    g_p     = clamp_dim(32'(r_patch), PATCH_MAX);
    g_s     = (r_stride != 0) ? 32'(r_stride) : g_p;
    g_total = g_ch * g_h * g_w;
    g_rows  = (g_h >= g_p) ? (g_h - g_p) / g_s + 1 : 0;
    g_cols  = (g_w >= g_p) ? (g_w - g_p) / g_s + 1 : 0;
    g_plen  = g_ch * g_p * g_p;
  endfunction

  function automatic void clear_sweep();
    prow = 0;
    pcol = 0;
    pchan = 0;
    prip = 0;
    pcip = 0;
    sweep_done = 1'b0;
  endfunction

  function automatic int unsigned image_elements();
    return g_rows * g_cols * g_plen;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CHANNELS:   r_channels = data[CHC_W-1:0];
      REG_HEIGHT:     r_height = data;
      REG_WIDTH:      r_width = data;
      REG_PATCH:      r_patch = data;
      REG_STRIDE:     r_stride = data;
      REG_CLASS_SLOT: r_class_slot = data[0];
      default:        return;
    endcase
    clear_sweep();
    refresh_geometry();
  endfunction

  function automatic void predict_request(cmd_code_t cmd, logic [PIX_W-1:0] word);
    longint unsigned slot, offs, addr;
    element_t e;
    e = '0;
    case (cmd)
      CMD_START: begin
        pix_loaded = 0;
        clear_sweep();
        return;
      end
      CMD_LOAD: begin
        if (pix_loaded >= g_total) begin
          e.status = ST_OVERFLOW;
        end else begin
          pix_mem[STORE_AW'(pix_loaded)] = word;
          pix_loaded++;
          e.status = ST_OK;
        end
      end
      CMD_EMIT: begin
        if (pix_loaded < g_total) begin
          e.status = ST_NOT_LOADED;
        end else if (sweep_done || g_rows == 0 || g_cols == 0) begin
          e.status = ST_EMPTY;
        end else begin
          slot = 64'(prow * g_cols + pcol + 32'(r_class_slot));
          offs = 64'((pchan * g_p + prip) * g_p + pcip);
          addr = 64'((pchan * g_h + prow * g_s + prip) * g_w + pcol * g_s + pcip);
          e.word  = pix_mem[STORE_AW'(addr % STORE_WORDS)];
          e.index = IDX_W'(slot * g_plen + offs);
          e.status = ST_OK;
          // column, row, channel, then patch column and patch row
          pcip++;
          if (pcip >= g_p) begin
            pcip = 0;
            prip++;
            if (prip >= g_p) begin
              prip = 0;
              pchan++;
              if (pchan >= g_ch) begin
                pchan = 0;
                e.patch_end = 1'b1;
                pcol++;
                if (pcol >= g_cols) begin
                  pcol = 0;
                  prow++;
                  if (prow >= g_rows) begin
                    prow = 0;
                    e.image_end = 1'b1;
                    sweep_done = 1'b1;
                  end
                end
              end
            end
          end
        end
      end
      default: return;
    endcase
    expected_q.push_back(e);
  endfunction

  task automatic send_request(cmd_code_t cmd, logic [PIX_W-1:0] word);
    int unsigned gap;
    gap = no_stall ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.pixel_word <= word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_request(cmd, word);
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    // a trailing start has no result, give it time to retire
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic emit_elements(int unsigned count);
    repeat (count) send_request(CMD_EMIT, '0);
  endtask

  task automatic test_reset_state();
    send_request(CMD_EMIT, '0);
    send_request(CMD_UNUSED, 32'hDEAD_BEEF);
  endtask

  task automatic test_small_image();
    wait_idle();
    write_register(REG_CHANNELS, 7'd1);
    write_register(REG_HEIGHT, 7'd2);
    write_register(REG_WIDTH, 7'd3);
    write_register(REG_PATCH, 7'd2);
    write_register(REG_STRIDE, 7'd1);
    write_register(REG_CLASS_SLOT, 7'd0);
    send_request(CMD_START, '0);
    send_request(CMD_LOAD, 32'h0000_0000);
    send_request(CMD_LOAD, 32'hFFFF_FFFF);
    send_request(CMD_LOAD, 32'h5555_5555);
    // emit while the image is still partly loaded
    send_request(CMD_EMIT, '0);
    send_request(CMD_LOAD, 32'hAAAA_AAAA);
    send_request(CMD_LOAD, 32'h0000_0001);
    send_request(CMD_LOAD, 32'h8000_0000);
    // store already full
    send_request(CMD_LOAD, 32'h1234_5678);
    emit_elements(image_elements() + 1);
    // a register write restarts the sweep, load count kept
    wait_idle();
    write_register(REG_CLASS_SLOT, 7'd1);
    emit_elements(2);
  endtask

  task automatic test_register_saturation();
    wait_idle();
    // patch clipped to 64, larger than the image
    write_register(REG_PATCH, 7'd127);
    send_request(CMD_EMIT, '0);
    wait_idle();
    write_register(REG_CHANNELS, 7'd0);
    write_register(REG_HEIGHT, 7'd0);
    write_register(REG_WIDTH, 7'd0);
    write_register(REG_PATCH, 7'd0);
    write_register(REG_STRIDE, 7'd127);
    emit_elements(2);
    wait_idle();
    write_register(REG_CHANNELS, 7'd7);
    emit_elements(5);
  endtask

  task automatic test_full_store();
    wait_idle();
    write_register(REG_CHANNELS, 7'd4);
    write_register(REG_HEIGHT, 7'd8);
    write_register(REG_WIDTH, 7'd8);
    write_register(REG_PATCH, 7'd1);
    write_register(REG_STRIDE, 7'd7);
    write_register(REG_CLASS_SLOT, 7'd1);
    send_request(CMD_START, '0);
    repeat (g_total) send_request(CMD_LOAD, $urandom());
    send_request(CMD_LOAD, $urandom());
    // single pixels at the four corners of every channel
    emit_elements(image_elements() + 1);
    wait_idle();
    write_register(REG_PATCH, 7'd8);
    write_register(REG_STRIDE, 7'd0);
    emit_elements(64);
  endtask

  task automatic test_random_images();
    int unsigned target, n_load, n_emit, half;
    target = requests_sent + 650;
    while (requests_sent < target) begin
      wait_idle();
      no_stall = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) != 0)
        write_register(REG_CHANNELS, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
                       $urandom_range(0, 7) : $urandom_range(1, 4)));
      if ($urandom_range(0, 2) != 0)
        write_register(REG_HEIGHT, CFG_DATA_W'(($urandom_range(0, 15) == 0) ?
                       $urandom_range(0, 1) * $urandom_range(9, 16) : $urandom_range(1, 8)));
      if ($urandom_range(0, 2) != 0)
        write_register(REG_WIDTH, CFG_DATA_W'(($urandom_range(0, 15) == 0) ?
                       $urandom_range(0, 1) * $urandom_range(9, 16) : $urandom_range(1, 8)));
      if ($urandom_range(0, 2) != 0)
        write_register(REG_PATCH, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
                       $urandom_range(0, 127) : $urandom_range(1, 4)));
      if ($urandom_range(0, 2) != 0)
        write_register(REG_STRIDE, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
                       $urandom_range(5, 127) : $urandom_range(0, 4)));
      if ($urandom_range(0, 2) != 0)
        write_register(REG_CLASS_SLOT, CFG_DATA_W'($urandom_range(0, 1)));

      if ($urandom_range(0, 5) == 0)
        send_request($urandom_range(0, 1) ? CMD_EMIT : CMD_UNUSED, $urandom());
      send_request(CMD_START, '0);

      n_load = g_total;
      case ($urandom_range(0, 9))
        0: n_load = $urandom_range(0, g_total - 1);
        1: n_load = g_total + $urandom_range(1, 3);
        default: ;
      endcase
      repeat (n_load) begin
        case ($urandom_range(0, 79))
          0: send_request(CMD_EMIT, '0);
          1: send_request(CMD_UNUSED, $urandom());
          2: if ($urandom_range(0, 3) == 0) send_request(CMD_START, '0);
          default: ;
        endcase
        send_request(CMD_LOAD, $urandom());
      end

      n_emit = image_elements();
      if (n_emit > 200) n_emit = 200;
      n_emit += $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) begin
        half = n_emit / 2;
        emit_elements(half);
        wait_idle();
        write_register(REG_CLASS_SLOT, CFG_DATA_W'($urandom_range(0, 1)));
      end
      repeat (n_emit) begin
        if ($urandom_range(0, 39) == 0) send_request(CMD_UNUSED, $urandom());
        send_request(CMD_EMIT, '0);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stalls, compare against the oldest expectation
  initial begin
    element_t want;
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = no_stall ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (expected_q.size() == 0) begin
        $error("unexpected result: word %h index %0d status %0d",
               out_ch.element_word, out_ch.element_index, out_ch.status);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.element_word !== want.word) begin
          $error("element_word: expected %h, got %h", want.word, out_ch.element_word);
          mismatch_count++;
        end
        if (out_ch.element_index !== want.index) begin
          $error("element_index: expected %0d, got %0d", want.index, out_ch.element_index);
          mismatch_count++;
        end
        if (out_ch.patch_end !== want.patch_end) begin
          $error("patch_end: expected %b, got %b", want.patch_end, out_ch.patch_end);
          mismatch_count++;
        end
        if (out_ch.image_end !== want.image_end) begin
          $error("image_end: expected %b, got %b", want.image_end, out_ch.image_end);
          mismatch_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #25_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_CHANNELS;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_START;
    in_ch.pixel_word <= '0;
    mismatch_count = 0;
    requests_sent  = 0;
    no_stall       = 1'b0;
    r_channels     = 3'd3;
    r_height       = 7'd64;
    r_width        = 7'd64;
    r_patch        = 7'd16;
    r_stride       = 7'd0;
    r_class_slot   = 1'b0;
    pix_loaded     = 0;
    clear_sweep();
    refresh_geometry();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_small_image();
    test_register_saturation();
    test_full_store();
    test_random_images();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
